### rtl/core/ccsk_pkg.sv
// ---------------------------------------------------------------------------
// ccsk_pkg
// Shared types and constants for the clock-sync keepalive client.
// ---------------------------------------------------------------------------
package ccsk_pkg;

  // action codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_REPLY     = 3'd1;
  localparam logic [2:0] ACT_PING      = 3'd2;
  localparam logic [2:0] ACT_GAP       = 3'd3;
  localparam logic [2:0] ACT_WORK_PING = 3'd4;

  // register map (index = byte address / 4)
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_MAX_HALF_RT  = 2'd0;
  localparam logic [1:0] REG_SYNC_PERIOD  = 2'd1;
  localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd2;

  // register reset values
  localparam logic [30:0] MAX_HALF_RT_RESET   = 31'd1000;
  localparam logic [30:0] SYNC_PERIOD_RESET   = 31'd9000;
  localparam logic [31:0] REPLY_TIMEOUT_RESET = 32'd120000;

  typedef struct packed {
    logic [30:0] max_half_round_trip;
    logic [30:0] sync_period;
    logic [31:0] reply_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic        logged_in;
    logic [31:0] server_stamp;
    logic [31:0] reference_time;
  } item_t;

  typedef struct packed {
    logic               send_request;
    logic [31:0]        request_global_time;
    logic [31:0]        request_index;
    logic               request_work_ping;
    logic [31:0]        round_trip;
    logic               link_alive;
    logic [31:0]        global_est;
    logic [31:0]        gap_time;
    logic signed [31:0] lost_total;
    logic signed [31:0] clock_step;
  } result_t;

endpackage

### rtl/core/ccsk_cfg.sv
// ---------------------------------------------------------------------------
// ccsk_cfg
// APB register file holding the three timing registers.
// ---------------------------------------------------------------------------
module ccsk_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccsk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ccsk_pkg::cfg_t              cfg
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ccsk_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_half_round_trip <= ccsk_pkg::MAX_HALF_RT_RESET;
      cfg.sync_period         <= ccsk_pkg::SYNC_PERIOD_RESET;
      cfg.reply_timeout       <= ccsk_pkg::REPLY_TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        ccsk_pkg::REG_MAX_HALF_RT:   cfg.max_half_round_trip <= pwdata[30:0];
        ccsk_pkg::REG_SYNC_PERIOD:   cfg.sync_period         <= pwdata[30:0];
        ccsk_pkg::REG_REPLY_TIMEOUT: cfg.reply_timeout       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ccsk_pkg::REG_MAX_HALF_RT:   prdata = {1'b0, cfg.max_half_round_trip};
      ccsk_pkg::REG_SYNC_PERIOD:   prdata = {1'b0, cfg.sync_period};
      ccsk_pkg::REG_REPLY_TIMEOUT: prdata = cfg.reply_timeout;
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/ccsk_engine.sv
// ---------------------------------------------------------------------------
// ccsk_engine
// Sync state and the single-pass update for one word.
// ---------------------------------------------------------------------------
module ccsk_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ccsk_pkg::item_t   item,
  input  ccsk_pkg::cfg_t    cfg,
  output ccsk_pkg::result_t res
);

  logic [31:0] server_base, server_base_next;
  logic [31:0] local_base, local_base_next;
  logic [31:0] last_send, last_send_next;
  logic [31:0] last_reply, last_reply_next;
  logic [31:0] last_round_trip, last_round_trip_next;
  logic [31:0] lost_count, lost_count_next;
  logic [31:0] sent_since_check, sent_since_check_next;
  logic [31:0] replies_since_check, replies_since_check_next;
  logic [31:0] step_error, step_error_next;
  logic [31:0] next_index, next_index_next;
  logic        work_ping, work_ping_next;

  logic [31:0] est_before, est_after;
  logic [31:0] since, moved, rt, mag, half, new_base, rep_inc;
  logic [31:0] reply_age;
  logic        blocked, go, accept;

  assign est_before = (server_base != 32'd0) ? server_base + (item.now_ms - local_base) : 32'd0;
  assign since      = item.now_ms - last_send;
  assign moved      = last_reply + (since - {1'b0, cfg.sync_period});
  assign blocked    = (last_send != 32'd0) && (since < {1'b0, cfg.sync_period});
  assign go         = item.logged_in && !blocked;
  // round trip read as signed, halved toward zero
  assign rt         = item.now_ms - last_send;
  assign mag        = 32'd0 - rt;
  assign half       = rt[31] ? (32'd0 - (mag >> 1)) : (rt >> 1);
  assign accept     = half <= {1'b0, cfg.max_half_round_trip};
  assign new_base   = item.server_stamp + half;
  assign rep_inc    = replies_since_check + 32'd1;
  assign reply_age  = item.now_ms - last_reply;

  always_comb begin
    server_base_next         = server_base;
    local_base_next          = local_base;
    last_send_next           = last_send;
    last_reply_next          = last_reply;
    last_round_trip_next     = last_round_trip;
    lost_count_next          = lost_count;
    sent_since_check_next    = sent_since_check;
    replies_since_check_next = replies_since_check;
    step_error_next          = step_error;
    next_index_next          = next_index;
    work_ping_next           = work_ping;
    est_after                = est_before;

    res                     = '0;
    case (item.action)
      ccsk_pkg::ACT_TICK: begin
        if (go) begin
          // late tick pulls the reply time forward, capped at now
          if (last_send != 32'd0 && last_reply != 32'd0) begin
            last_reply_next = (item.now_ms < moved) ? item.now_ms : moved;
          end
          res.send_request        = 1'b1;
          res.request_global_time = est_before;
          res.request_index       = next_index;
          res.request_work_ping   = work_ping;
          last_send_next          = item.now_ms;
          sent_since_check_next   = sent_since_check + 32'd1;
          next_index_next         = next_index + 32'd1;
          work_ping_next          = 1'b0;
        end
      end
      ccsk_pkg::ACT_REPLY: begin
        last_round_trip_next = rt;
        if (accept) begin
          server_base_next = new_base;
          local_base_next  = item.now_ms;
          est_after        = new_base;
          step_error_next  = new_base - est_before;
        end
        if (rep_inc != sent_since_check) begin
          lost_count_next          = lost_count + (sent_since_check - rep_inc);
          sent_since_check_next    = 32'd0;
          replies_since_check_next = 32'd0;
        end else begin
          replies_since_check_next = rep_inc;
        end
        last_reply_next = item.now_ms;
      end
      ccsk_pkg::ACT_PING: begin
        res.link_alive = 1'b1;
        if (last_send != 32'd0 && last_reply != 32'd0 && reply_age > cfg.reply_timeout) begin
          last_reply_next = 32'd0;
          res.link_alive  = 1'b0;
        end
      end
      ccsk_pkg::ACT_GAP: begin
        res.gap_time = (est_before > item.reference_time) ?
                       est_before - item.reference_time : 32'd0;
      end
      ccsk_pkg::ACT_WORK_PING: begin
        work_ping_next = 1'b1;
      end
      default: ;
    endcase

    res.round_trip  = last_round_trip_next;
    res.global_est  = est_after;
    res.lost_total  = $signed(lost_count_next);
    res.clock_step  = $signed(step_error_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_base         <= 32'd0;
      local_base          <= 32'd0;
      last_send           <= 32'd0;
      last_reply          <= 32'd0;
      last_round_trip     <= 32'd0;
      lost_count          <= 32'd0;
      sent_since_check    <= 32'd0;
      replies_since_check <= 32'd0;
      step_error          <= 32'd0;
      next_index          <= 32'd0;
      work_ping           <= 1'b0;
    end else if (step) begin
      server_base         <= server_base_next;
      local_base          <= local_base_next;
      last_send           <= last_send_next;
      last_reply          <= last_reply_next;
      last_round_trip     <= last_round_trip_next;
      lost_count          <= lost_count_next;
      sent_since_check    <= sent_since_check_next;
      replies_since_check <= replies_since_check_next;
      step_error          <= step_error_next;
      next_index          <= next_index_next;
      work_ping           <= work_ping_next;
    end
  end

endmodule

### rtl/core/client_clock_sync_keepalive.sv
// ---------------------------------------------------------------------------
// client_clock_sync_keepalive
// Client side of a periodic round-trip clock-sync exchange with keepalive.
// ---------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   item      item_valid / item_ready / item            in
//   result    result_valid / result_ready / result      out
//   config    psel penable pwrite paddr pwdata prdata   apb, pready tied high
//
// one word per cycle sustained while results are drained; a word waits in the input
// register until the result register can load, and its result is registered there
// the state update and result for a word happen in the same edge, so words
// that follow each other back to back see the fully updated state
// the result register decouples the sides: a new word is taken while a
// finished result still waits, as long as that result is leaving or the
// input register is empty
// synchronous active-high reset clears state and valids and resets the config registers
// ---------------------------------------------------------------------------
module client_clock_sync_keepalive (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_ready,
  input  ccsk_pkg::item_t             item,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output ccsk_pkg::result_t           result,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccsk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ccsk_pkg::cfg_t    cfg;
  ccsk_pkg::item_t   held;       // input register
  ccsk_pkg::result_t step_res;
  logic              held_valid;
  logic              advance;    // result register can load
  logic              step;       // held word is processed this edge

  assign advance    = !result_valid || result_ready;
  assign step       = held_valid && advance;
  assign item_ready = !held_valid || advance;

  ccsk_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccsk_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held),
    .cfg  (cfg),
    .res  (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= step_res;
    end
  end

endmodule

### rtl/core/ccsk_checker.sv
// ---------------------------------------------------------------------------
// ccsk_checker
// Port-level checks for the clock-sync keepalive client.
// ---------------------------------------------------------------------------
module ccsk_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input ccsk_pkg::result_t result
);

  // result register comes out of reset empty
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // request fields are zero unless a request went out
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.send_request |->
      result.request_index == 32'd0 && result.request_global_time == 32'd0 &&
      !result.request_work_ping)
    else $error("request fields set without request");

  // a nonzero gap needs a nonzero estimate
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.gap_time != 32'd0 |-> result.global_est != 32'd0)
    else $error("gap without global estimate");

  // a tick never reports link status
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.send_request && result.link_alive))
    else $error("request and link status in one word");

endmodule

bind client_clock_sync_keepalive ccsk_checker u_ccsk_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock-sync keepalive client. Words go in through
// the item channel under random bursts, results are drained under a random
// stall pattern and compared field by field against an in-bench model of the
// client. Registers are rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;

  // action codes that the block ignores
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int unsigned WORDS_PER_PHASE = 75;
  localparam int unsigned PHASES = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_ready;
  ccsk_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  ccsk_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ccsk_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  client_clock_sync_keepalive uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // client model: register copy and sync state, all starting from reset values
  // ---------------------------------------------------------------------------
  logic [30:0] cfg_max_half = ccsk_pkg::MAX_HALF_RT_RESET;
  logic [30:0] cfg_period   = ccsk_pkg::SYNC_PERIOD_RESET;
  logic [31:0] cfg_timeout  = ccsk_pkg::REPLY_TIMEOUT_RESET;

  logic [31:0] srv_base      = '0;  // 0 = not synced
  logic [31:0] loc_base      = '0;
  logic [31:0] last_req_ms   = '0;  // 0 = never sent
  logic [31:0] last_reply_ms = '0;  // 0 = no reply seen
  logic [31:0] last_rtt      = '0;
  logic [31:0] lost_cnt      = '0;
  logic [31:0] reqs_open     = '0;
  logic [31:0] replies_open  = '0;
  logic [31:0] step_err      = '0;
  logic [31:0] req_seq       = '0;
  logic        work_flag     = 1'b0;

  ccsk_pkg::result_t reports_due[$];   // expected results, oldest first
  int unsigned fault_count = 0;

  // global time estimate at a local time stamp
  function automatic logic [31:0] global_at(input logic [31:0] now);
    return (srv_base != 32'd0) ? srv_base + (now - loc_base) : 32'd0;
  endfunction

  // signed halving toward zero, result taken back as unsigned
  function automatic logic [31:0] halve_delay(input logic [31:0] d);
    logic [31:0] mag;
    mag = -d;
    return d[31] ? -(mag >> 1) : (d >> 1);
  endfunction

  task automatic advance_sync_client(input ccsk_pkg::item_t w,
                                     output ccsk_pkg::result_t r);
    logic [31:0] since, moved, rt, half, est_prior, g;
    logic go;
    r = '0;
    case (w.action)
      ccsk_pkg::ACT_TICK: begin
        go = w.logged_in;
        if (go && last_req_ms != 32'd0) begin
          since = w.now_ms - last_req_ms;
          if (since < {1'b0, cfg_period}) begin
            go = 1'b0;
          end else if (last_reply_ms != 32'd0) begin
            // late tick drags the reply time forward, capped at now
            moved = last_reply_ms + (since - {1'b0, cfg_period});
            last_reply_ms = (w.now_ms < moved) ? w.now_ms : moved;
          end
        end
        if (go) begin
          r.send_request        = 1'b1;
          r.request_global_time = global_at(w.now_ms);
          r.request_index       = req_seq;
          r.request_work_ping   = work_flag;
          last_req_ms  = w.now_ms;
          reqs_open    = reqs_open + 32'd1;
          req_seq      = req_seq + 32'd1;
          work_flag    = 1'b0;
        end
      end
      ccsk_pkg::ACT_REPLY: begin
        rt = w.now_ms - last_req_ms;
        half = halve_delay(rt);
        last_rtt = rt;
        if (half <= {1'b0, cfg_max_half}) begin
          est_prior = global_at(w.now_ms);
          srv_base  = w.server_stamp + half;
          loc_base  = w.now_ms;
          step_err  = global_at(w.now_ms) - est_prior;
        end
        replies_open = replies_open + 32'd1;
        if (replies_open != reqs_open) begin
          lost_cnt     = lost_cnt + (reqs_open - replies_open);
          reqs_open    = '0;
          replies_open = '0;
        end
        last_reply_ms = w.now_ms;
      end
      ccsk_pkg::ACT_PING: begin
        r.link_alive = 1'b1;
        if (last_req_ms != 32'd0 && last_reply_ms != 32'd0 &&
            (w.now_ms - last_reply_ms) > cfg_timeout) begin
          last_reply_ms = '0;
          r.link_alive  = 1'b0;
        end
      end
      ccsk_pkg::ACT_GAP: begin
        g = global_at(w.now_ms);
        r.gap_time = (g > w.reference_time) ? g - w.reference_time : 32'd0;
      end
      ccsk_pkg::ACT_WORK_PING: begin
        work_flag = 1'b1;
      end
      default: begin
      end
    endcase
    r.round_trip  = last_rtt;
    r.global_est  = global_at(w.now_ms);
    r.lost_total  = lost_cnt;
    r.clock_step  = step_err;
  endtask

  // result with every field zero except the three flags
  function automatic ccsk_pkg::result_t plain_report(input logic snd, input logic png,
                                                     input logic alv);
    ccsk_pkg::result_t r;
    r = '0;
    r.send_request      = snd;
    r.request_work_ping = png;
    r.link_alive        = alv;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and field-by-field compare
  // ---------------------------------------------------------------------------
  logic [31:0] stall_mask = '1;
  logic [4:0]  stall_pos  = '0;
  ccsk_pkg::result_t want_r;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    // values read here are the ones from just before the edge
    if (!rst && result_valid && result_ready) begin
      if (reports_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("mismatch: result word with nothing expected");
      end else begin
        want_r = reports_due.pop_front();
        check_field("send_request", 32'(want_r.send_request),
                    32'(result.send_request));
        check_field("request_global_time", want_r.request_global_time,
                    result.request_global_time);
        check_field("request_index", want_r.request_index, result.request_index);
        check_field("request_work_ping", 32'(want_r.request_work_ping),
                    32'(result.request_work_ping));
        check_field("round_trip", want_r.round_trip, result.round_trip);
        check_field("link_alive", 32'(want_r.link_alive), 32'(result.link_alive));
        check_field("global_est", want_r.global_est, result.global_est);
        check_field("gap_time", want_r.gap_time, result.gap_time);
        check_field("lost_total", want_r.lost_total, result.lost_total);
        check_field("clock_step", want_r.clock_step, result.clock_step);
      end
    end
    // when stall_pos wraps, pick a new pattern: open, random, mostly open, mostly shut
    if (stall_pos == 5'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask = '1;
        1:       stall_mask = $urandom;
        2:       stall_mask = $urandom | $urandom;
        default: stall_mask = $urandom & $urandom & $urandom;
      endcase
    end
    result_ready <= stall_mask[stall_pos];
    stall_pos = stall_pos + 5'd1;
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------
  typedef struct {
    ccsk_pkg::item_t   w;
    bit                typed;  // expected result written in by hand
    ccsk_pkg::result_t want;
  } stim_row_t;

  stim_row_t dir_tab[$];
  int unsigned burst_left = 0;
  logic [31:0] t_ms = '0;        // local clock of the well-formed sequences
  logic [31:0] srv_offset = '0;  // server clock minus local clock

  task automatic add_row(input logic [2:0] act, input logic [31:0] now,
                         input logic li, input logic [31:0] stamp,
                         input logic [31:0] ref_time, input bit typed,
                         input ccsk_pkg::result_t want);
    stim_row_t r;
    r.w.action         = act;
    r.w.now_ms         = now;
    r.w.logged_in      = li;
    r.w.server_stamp   = stamp;
    r.w.reference_time = ref_time;
    r.typed            = typed;
    r.want             = want;
    dir_tab.push_back(r);
  endtask

  // offer one word, hold it until taken, then queue its expected result
  // called right after a rising edge; leaves valid high for the caller
  task automatic push_word(input ccsk_pkg::item_t w, input bit typed,
                           input ccsk_pkg::result_t want);
    ccsk_pkg::result_t r;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    advance_sync_client(w, r);
    reports_due.push_back(typed ? want : r);
  endtask

  // bursts of random length, most of them followed by a short gap
  task automatic sender_idle();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop sending until every expected result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ccsk_pkg::REG_MAX_HALF_RT:   cfg_max_half = val[30:0];
      ccsk_pkg::REG_SYNC_PERIOD:   cfg_period   = val[30:0];
      ccsk_pkg::REG_REPLY_TIMEOUT: cfg_timeout  = val;
      default: begin
      end
    endcase
  endtask

  // one random word: mostly a plausible exchange on a running clock,
  // the rest noise with every field drawn freely
  task automatic draw_word(output ccsk_pkg::item_t w);
    int unsigned pick;
    logic [31:0] rt_span;
    pick = $urandom_range(0, 99);
    rt_span = (cfg_max_half > 31'd2000) ? 32'd4000 : {cfg_max_half, 1'b0} + 32'd2;
    w.logged_in = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 3) == 0) begin
      w.action         = 3'($urandom_range(0, 7));
      w.now_ms         = $urandom;
      w.logged_in      = 1'($urandom_range(0, 1));
      w.server_stamp   = $urandom;
      w.reference_time = $urandom;
    end else begin
      if (pick < 35) begin
        w.action = ccsk_pkg::ACT_TICK;
        pick = $urandom_range(0, 9);
        if (pick < 6)
          t_ms = t_ms + $urandom_range(0, 3000);
        else if (pick < 9)
          t_ms = t_ms + {1'b0, cfg_period} + $urandom_range(0, 2000);
        else
          t_ms = t_ms + $urandom_range(0, 300000);
      end else if (pick < 60) begin
        w.action = ccsk_pkg::ACT_REPLY;
        t_ms = t_ms + $urandom_range(0, rt_span);
      end else if (pick < 72) begin
        w.action = ccsk_pkg::ACT_PING;
        // land around the timeout edge half of the time
        if ($urandom_range(0, 1) == 0)
          t_ms = t_ms + $urandom_range(0, 2000);
        else
          t_ms = t_ms + cfg_timeout - 32'd100 + $urandom_range(0, 200);
      end else begin
        if (pick < 87)
          w.action = ccsk_pkg::ACT_GAP;
        else if (pick < 95)
          w.action = ccsk_pkg::ACT_WORK_PING;
        else
          w.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        t_ms = t_ms + $urandom_range(0, 500);
      end
      w.now_ms         = t_ms;
      w.server_stamp   = t_ms + srv_offset + $urandom_range(0, 100);
      w.reference_time = t_ms + srv_offset - 32'd5000 + $urandom_range(0, 10000);
    end
  endtask

  initial begin
    ccsk_pkg::item_t w;
    logic [31:0] mh, sp, to;
    int unsigned counted;
    bit pressed;
    int unsigned spin;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words, registers at reset values
    // fresh state: no sync, so gap and unused codes give all zeros
    add_row(ccsk_pkg::ACT_GAP, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b1, '0);
    add_row(ACT_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
    add_row(ACT_UNUSED_LO, 32'h1234_5678, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '0);
    // not logged in: the tick does nothing
    add_row(ccsk_pkg::ACT_TICK, 32'd5000, 1'b0, 32'h0, 32'h0, 1'b1, '0);
    // nothing sent yet: link counts as alive
    add_row(ccsk_pkg::ACT_PING, 32'd777, 1'b0, 32'h0, 32'h0, 1'b1,
            plain_report(1'b0, 1'b0, 1'b1));
    add_row(ccsk_pkg::ACT_WORK_PING, 32'd50, 1'b0, 32'h0, 32'h0, 1'b1, '0);
    // first request: index 0, carries the work ping, no global time yet
    add_row(ccsk_pkg::ACT_TICK, 32'd100, 1'b1, 32'h0, 32'h0, 1'b1,
            plain_report(1'b1, 1'b1, 1'b0));
    // too early for the next request
    add_row(ccsk_pkg::ACT_TICK, 32'd200, 1'b1, 32'h0, 32'h0, 1'b0, '0);
    // accepted reply, server stamp wraps
    add_row(ccsk_pkg::ACT_REPLY, 32'd300, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_GAP, 32'd400, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_GAP, 32'd400, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
    // late tick pulls the reply time forward
    add_row(ccsk_pkg::ACT_TICK, 32'd20000, 1'b1, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_PING, 32'd20001, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_TICK, 32'd40000, 1'b1, 32'h0, 32'h0, 1'b0, '0);
    // replies fewer than requests: a loss is booked
    add_row(ccsk_pkg::ACT_REPLY, 32'd40010, 1'b0, 32'd5000000, 32'h0, 1'b0, '0);
    // delay of minus one halves to zero and is accepted
    add_row(ccsk_pkg::ACT_REPLY, 32'd39999, 1'b0, 32'd123, 32'h0, 1'b0, '0);
    // negative delay and too long a round trip are refused
    add_row(ccsk_pkg::ACT_REPLY, 32'd30000, 1'b0, 32'd999, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_REPLY, 32'd45000, 1'b0, 32'd999, 32'h0, 1'b0, '0);
    // just past the reply timeout: dead, then alive again with no reply stamp
    add_row(ccsk_pkg::ACT_PING, 32'd165001, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_PING, 32'd165002, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    // send at local time zero, then a reply that leaves the server base at zero
    add_row(ccsk_pkg::ACT_TICK, 32'd0, 1'b1, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_REPLY, 32'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    // last send stamp of zero reads as never sent
    add_row(ccsk_pkg::ACT_TICK, 32'd1, 1'b1, 32'h0, 32'h0, 1'b0, '0);
    add_row(ccsk_pkg::ACT_GAP, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'd1, 1'b0, '0);

    foreach (dir_tab[i]) begin
      push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
      sender_idle();
    end
    wait_drained();

    // random phases: reset values, all zero, all ones, moderate, anything
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          mh = {1'b0, ccsk_pkg::MAX_HALF_RT_RESET};
          sp = {1'b0, ccsk_pkg::SYNC_PERIOD_RESET};
          to = ccsk_pkg::REPLY_TIMEOUT_RESET;
        end
        1: begin
          mh = '0;
          sp = '0;
          to = '0;
        end
        2: begin
          mh = '1;
          sp = '1;
          to = '1;
        end
        3: begin
          mh = $urandom_range(0, 5000);
          sp = $urandom_range(1, 20000);
          to = $urandom_range(100, 50000);
        end
        default: begin
          mh = $urandom;
          sp = $urandom;
          to = $urandom;
        end
      endcase
      apb_write(ccsk_pkg::REG_MAX_HALF_RT, mh);
      apb_write(ccsk_pkg::REG_SYNC_PERIOD, sp);
      apb_write(ccsk_pkg::REG_REPLY_TIMEOUT, to);
      @(posedge clk);

      t_ms = $urandom;
      srv_offset = $urandom;
      counted = 0;
      pressed = 0;
      while (counted < WORDS_PER_PHASE) begin
        draw_word(w);
        push_word(w, 1'b0, '0);
        if (w.action <= ccsk_pkg::ACT_WORK_PING)
          counted++;
        // mid-phase, hold off until the result side has caught up
        if (!pressed && counted >= WORDS_PER_PHASE / 2) begin
          pressed = 1;
          wait_drained();
        end else begin
          sender_idle();
        end
      end
      wait_drained();
    end

    // all stimulus taken: let the last results out, bounded
    item_valid <= 1'b0;
    spin = 0;
    while (reports_due.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (fault_count == 0 && reports_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
